// ===== rtl/checked_integer_alu_macros.svh =====
// Assertion macros for the checked integer ALU.
// Used by the top level only; depends on nothing else.
`ifndef CHECKED_INTEGER_ALU_MACROS_SVH
`define CHECKED_INTEGER_ALU_MACROS_SVH

// Assert that a property holds at every clock edge outside reset.
`define CIA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert a property that also holds during reset.
`define CIA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/cia_pkg.sv =====
// Package for the checked integer ALU: operation and fault codes, beat types.
// Used by every module of the block; depends on nothing.
package cia_pkg;

   localparam int unsigned DivSteps = 64;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_MUL    = 3'd2,
      OP_DIV    = 3'd3,
      OP_MOD    = 3'd4,
      OP_NEG    = 3'd5,
      OP_NARROW = 3'd6,
      OP_ABS    = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      FAULT_NONE      = 3'd0,
      FAULT_OVERFLOW  = 3'd1,
      FAULT_UNDERFLOW = 3'd2,
      FAULT_DIV_ZERO  = 3'd3,
      FAULT_MIN_NEG1  = 3'd4
   } fault_type;

   // Classified beat passed from the front end to the back end.
   typedef struct packed {
      op_type      op;
      logic        wide;
      logic [63:0] a;
      logic [63:0] b;
      fault_type   early_fault;
   } item_type;

endpackage

// ===== rtl/cia_front.sv =====
// Front end of the checked integer ALU: sign-extends operands and flags the
// faults that depend on the operands alone. Depends on cia_pkg.
module cia_front (
   input  logic [2:0]        kind,
   input  logic              wide,
   input  logic [63:0]       operand_a,
   input  logic [63:0]       operand_b,
   output cia_pkg::item_type item
);
   import cia_pkg::*;

   logic [63:0] a_ext;
   logic [63:0] b_ext;
   logic [63:0] min_val;
   logic        a_is_min;
   logic        b_zero;
   logic        b_neg1;
   fault_type   fault;

   // Operands in the selected width, sign-extended to 64 bits.
   assign a_ext   = wide ? operand_a : {{32{operand_a[31]}}, operand_a[31:0]};
   assign b_ext   = wide ? operand_b : {{32{operand_b[31]}}, operand_b[31:0]};
   assign min_val = wide ? 64'h8000_0000_0000_0000 : 64'hFFFF_FFFF_8000_0000;
   assign a_is_min = (a_ext == min_val);
   assign b_zero   = (b_ext == 64'd0);
   assign b_neg1   = (b_ext == '1);

   // Faults for division, negate, abs and narrow.
   always_comb begin
      fault = FAULT_NONE;
      case (op_type'(kind))
         OP_DIV, OP_MOD: begin
            if (b_zero) fault = FAULT_DIV_ZERO;
            else if (a_is_min && b_neg1) fault = FAULT_MIN_NEG1;
         end
         OP_NEG, OP_ABS: begin
            if (a_is_min) fault = FAULT_OVERFLOW;
         end
         OP_NARROW: begin
            if (operand_a[63:31] != {33{operand_a[31]}}) fault = FAULT_OVERFLOW;
         end
         default: fault = FAULT_NONE;
      endcase
   end

   assign item.op          = op_type'(kind);
   assign item.wide        = wide;
   assign item.a           = (op_type'(kind) == OP_NARROW) ? operand_a : a_ext;
   assign item.b           = b_ext;
   assign item.early_fault = fault;

endmodule

// ===== rtl/cia_queue.sv =====
// Two-entry queue between the front end and the back end.
// Depends on cia_pkg.
module cia_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cia_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output cia_pkg::item_type pop_item
);
   import cia_pkg::*;

   item_type  mem_ff [2];
   logic      wr_ptr_ff, wr_ptr_in;
   logic      rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_item  = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_item;
   end

endmodule

// ===== rtl/cia_back.sv =====
// Back end of the checked integer ALU: direct add, subtract, negate, abs and narrow, a
// pipelined multiplier built of 32x32 partial products, and a radix-2
// restoring divider. Depends on cia_pkg.
module cia_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  cia_pkg::item_type in_item,
   output logic              in_ready,
   output logic              out_valid,
   output logic [63:0]       out_value,
   output logic [2:0]        out_fault
);
   import cia_pkg::*;

   localparam int unsigned CntW = $clog2(DivSteps + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   item_type      cur_ff, cur_in;

   // Multiplier: magnitudes and four partial products.
   logic [63:0]   ma_ff, ma_in, mb_ff, mb_in;
   logic          mneg_ff, mneg_in;
   logic [63:0]   pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [127:0]  prod_ff;
   logic [1:0]    mstep_ff, mstep_in;

   // Divider.
   logic [63:0]   quo_ff, quo_in;
   logic [64:0]   rem_ff, rem_in;
   logic [63:0]   dvs_ff, dvs_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic          qneg_ff, qneg_in, rneg_ff, rneg_in;

   logic [63:0]   res_ff, res_in;
   fault_type     rf_ff, rf_in;

   logic [64:0]   sum, dif;
   logic [63:0]   abs_a, abs_b;
   logic [64:0]   rem_sh, rem_try;
   logic          direct;
   logic          take;
   logic [66:0]   quick_res;

   assign abs_a = in_item.a[63] ? (64'd0 - in_item.a) : in_item.a;
   assign abs_b = in_item.b[63] ? (64'd0 - in_item.b) : in_item.b;
   assign sum   = {in_item.a[63], in_item.a} + {in_item.b[63], in_item.b};
   assign dif   = {in_item.a[63], in_item.a} - {in_item.b[63], in_item.b};
   assign rem_sh  = {rem_ff[63:0], quo_ff[63]};
   assign rem_try = rem_sh - {1'b0, dvs_ff};

   assign in_ready  = (state_ff == ST_IDLE) || (state_ff == ST_DONE);
   assign take      = in_valid && in_ready;
   assign direct    = (in_item.early_fault != FAULT_NONE) ||
                      !((in_item.op == OP_MUL) || (in_item.op == OP_DIV) ||
                        (in_item.op == OP_MOD));
   assign out_valid = (state_ff == ST_DONE);
   assign out_value = res_ff;
   assign out_fault = rf_ff;

   // Range check of a signed 65-bit result in the chosen width.
   function automatic logic fits(input logic [64:0] v, input logic w);
      if (w) fits = (v[64] == v[63]);
      else   fits = (v[64:31] == {34{v[31]}});
   endfunction

   // Direct results for operations that bypass the multiplier and divider.
   function automatic logic [66:0] quick(input item_type it, input logic [64:0] s,
                                         input logic [64:0] d, input logic [63:0] aa);
      logic [63:0] r;
      fault_type   f;
      r = 64'd0;
      f = it.early_fault;
      if (f == FAULT_NONE) begin
         unique case (it.op)
            OP_ADD: begin
               if (fits(s, it.wide)) r = s[63:0];
               else f = s[64] ? FAULT_UNDERFLOW : FAULT_OVERFLOW;
            end
            OP_SUB: begin
               if (fits(d, it.wide)) r = d[63:0];
               else f = d[64] ? FAULT_UNDERFLOW : FAULT_OVERFLOW;
            end
            OP_NEG:    r = 64'd0 - it.a;
            OP_ABS:    r = aa;
            OP_NARROW: r = it.a;
            default:   r = 64'd0;
         endcase
      end
      quick = {f, r};
   endfunction

   assign quick_res = quick(in_item, sum, dif, abs_a);

   // Sequencer for the multiplier and divider.
   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      ma_in = ma_ff; mb_in = mb_ff; mneg_in = mneg_ff; mstep_in = mstep_ff;
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff; cnt_in = cnt_ff;
      qneg_in = qneg_ff; rneg_in = rneg_ff;
      res_in = res_ff; rf_in = rf_ff;
      unique case (state_ff)
         ST_IDLE, ST_DONE: begin
            state_in = ST_IDLE;
            if (take) begin
               cur_in = in_item;
               if (direct) begin
                  rf_in    = fault_type'(quick_res[66:64]);
                  res_in   = quick_res[63:0];
                  state_in = ST_DONE;
               end else if (in_item.op == OP_MUL) begin
                  ma_in = abs_a; mb_in = abs_b;
                  mneg_in  = in_item.a[63] ^ in_item.b[63];
                  mstep_in = 2'd0;
                  state_in = ST_MUL;
               end else begin
                  quo_in = abs_a; rem_in = 65'd0; dvs_in = abs_b;
                  cnt_in = CntW'(DivSteps);
                  qneg_in = in_item.a[63] ^ in_item.b[63];
                  rneg_in = in_item.a[63];
                  state_in = ST_DIV;
               end
            end
         end
         ST_MUL: begin
            mstep_in = mstep_ff + 2'd1;
            if (mstep_ff == 2'd2) begin
               state_in = ST_DONE;
               res_in = 64'd0;
               rf_in  = FAULT_OVERFLOW;
               if (mneg_ff) begin
                  if (prod_ff[127:63] == 65'd0 ||
                      (prod_ff[127:63] == 65'd1 && prod_ff[62:0] == 63'd0 &&
                       cur_ff.wide)) begin
                     if (cur_ff.wide) begin
                        res_in = 64'd0 - prod_ff[63:0];
                        rf_in  = FAULT_NONE;
                     end
                  end
                  if (!cur_ff.wide && prod_ff[127:31] == 97'd0 ||
                      !cur_ff.wide && prod_ff[127:31] == 97'd1 &&
                      prod_ff[30:0] == 31'd0) begin
                     res_in = 64'd0 - prod_ff[63:0];
                     rf_in  = FAULT_NONE;
                  end
               end else begin
                  if ((cur_ff.wide && prod_ff[127:63] == 65'd0) ||
                      (!cur_ff.wide && prod_ff[127:31] == 97'd0)) begin
                     res_in = prod_ff[63:0];
                     rf_in  = FAULT_NONE;
                  end
               end
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
               rf_in = FAULT_NONE;
               if (cur_ff.op == OP_DIV) res_in = qneg_ff ? (64'd0 - quo_ff) : quo_ff;
               else res_in = rneg_ff ? (64'd0 - rem_ff[63:0]) : rem_ff[63:0];
            end else begin
               cnt_in = cnt_ff - CntW'(1);
               if (!rem_try[64]) begin
                  rem_in = rem_try;
                  quo_in = {quo_ff[62:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  quo_in = {quo_ff[62:0], 1'b0};
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Payload and datapath registers.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      ma_ff <= ma_in; mb_ff <= mb_in; mneg_ff <= mneg_in; mstep_ff <= mstep_in;
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in; cnt_ff <= cnt_in;
      qneg_ff <= qneg_in; rneg_ff <= rneg_in;
      res_ff <= res_in; rf_ff <= rf_in;
      // Partial products, then their sum, one register stage each.
      pp_ll_ff <= ma_ff[31:0]  * mb_ff[31:0];
      pp_lh_ff <= ma_ff[31:0]  * mb_ff[63:32];
      pp_hl_ff <= ma_ff[63:32] * mb_ff[31:0];
      pp_hh_ff <= ma_ff[63:32] * mb_ff[63:32];
      prod_ff  <= {64'd0, pp_ll_ff} + {32'd0, pp_lh_ff, 32'd0} +
                  {32'd0, pp_hl_ff, 32'd0} + {pp_hh_ff, 64'd0};
   end

endmodule

// ===== rtl/checked_integer_alu.sv =====
// Top level of the checked integer ALU: front end, queue and back end.
// Depends on cia_pkg, cia_front, cia_queue, cia_back and the macro header.

// Checked signed integer ALU. Raise start with an operation while busy is
// low; each beat yields one result, shown on rsp_value and rsp_fault for one
// cycle with rsp_valid, which the receiver must take then. Path of a beat
// from acceptance, with the back end free: add, subtract, negate, abs,
// narrow and every operation trapped in the front end pass the queue, then
// the back-end result register; multiply passes the queue, the operand
// register, a register of four 32x32 partial products, their sum and the
// range check; divide and modulo pass the queue and the 64 steps of the
// one-bit-per-cycle divider. The back end works on one beat at a time: it
// takes a direct operation every cycle, but a multiply or divide holds it
// until its result is out, so a two-beat queue absorbs short bursts and busy
// rises when it is full. Results leave in order of acceptance.
`include "checked_integer_alu_macros.svh"

module checked_integer_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic        req_wide,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   output logic        rsp_valid,
   output logic [63:0] rsp_value,
   output logic [2:0]  rsp_fault
);
   import cia_pkg::*;

   item_type front_item;
   item_type queue_item;
   logic     q_full;
   logic     q_not_empty;
   logic     back_ready;
   logic     accept;

   assign busy   = q_full;
   assign accept = start && !busy;

   cia_front u_front (
      .kind      (req_kind),
      .wide      (req_wide),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .item      (front_item)
   );

   cia_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_not_empty && back_ready),
      .not_empty (q_not_empty),
      .pop_item  (queue_item)
   );

   cia_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_not_empty),
      .in_item   (queue_item),
      .in_ready  (back_ready),
      .out_valid (rsp_valid),
      .out_value (rsp_value),
      .out_fault (rsp_fault)
   );

   // A faulting result always carries a zero value.
   `CIA_ASSERT(a_fault_zero, clock, reset,
      (rsp_valid && rsp_fault != FAULT_NONE) |-> (rsp_value == 64'd0),
      "fault with nonzero value")
   // Fault codes stay within the defined set.
   `CIA_ASSERT(a_fault_range, clock, reset,
      rsp_valid |-> (rsp_fault <= FAULT_MIN_NEG1), "undefined fault code")
   // The handshake outputs are never unknown.
   `CIA_ASSERT(a_ctrl_known, clock, reset,
      !$isunknown({rsp_valid, busy}), "unknown handshake output")
   // Nothing comes out right after reset.
   `CIA_ASSERT_ALWAYS(a_reset_quiet, clock,
      $past(reset) |-> !rsp_valid, "result after reset")

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the checked integer ALU: directed and random beats.
// Depends on cia_pkg and the checked_integer_alu top level; reads no files.
`timescale 1ns / 1ps

// Holds expected results in order and compares each response against them.
class alu_scoreboard;
   logic [63:0] exp_value_q[$];
   logic [2:0]  exp_fault_q[$];
   int          mismatches = 0;
   int          checked = 0;

   // Works out the result of one beat and queues it.
   function void note_request(cia_pkg::op_type op, logic wide,
                              logic [63:0] a_raw, logic [63:0] b_raw);
      logic signed [63:0]  a;
      logic signed [63:0]  b;
      logic signed [63:0]  lo;
      logic signed [63:0]  hi;
      logic signed [127:0] full;
      logic signed [63:0]  r;
      cia_pkg::fault_type  f;
      a  = wide ? a_raw : {{32{a_raw[31]}}, a_raw[31:0]};
      b  = wide ? b_raw : {{32{b_raw[31]}}, b_raw[31:0]};
      lo = wide ? 64'sh8000000000000000 : -64'sd2147483648;
      hi = wide ? 64'sh7fffffffffffffff : 64'sd2147483647;
      r  = 0;
      f  = cia_pkg::FAULT_NONE;
      case (op)
         cia_pkg::OP_ADD, cia_pkg::OP_SUB: begin
            // Exact sum or difference in 128 bits, then range check.
            if (op == cia_pkg::OP_ADD) full = 128'(a) + 128'(b);
            else full = 128'(a) - 128'(b);
            if (full > 128'(hi)) f = cia_pkg::FAULT_OVERFLOW;
            else if (full < 128'(lo)) f = cia_pkg::FAULT_UNDERFLOW;
            else r = full[63:0];
         end
         cia_pkg::OP_MUL: begin
            full = 128'(a) * 128'(b);
            if (full > 128'(hi) || full < 128'(lo)) f = cia_pkg::FAULT_OVERFLOW;
            else r = full[63:0];
         end
         cia_pkg::OP_DIV, cia_pkg::OP_MOD: begin
            if (b == 0) f = cia_pkg::FAULT_DIV_ZERO;
            else if (a == lo && b == -1) f = cia_pkg::FAULT_MIN_NEG1;
            else r = (op == cia_pkg::OP_DIV) ? a / b : a % b;
         end
         cia_pkg::OP_NARROW: begin
            // Narrow always looks at all 64 bits, whatever the width flag.
            if ($signed(a_raw) > 64'sd2147483647 || $signed(a_raw) < -64'sd2147483648)
               f = cia_pkg::FAULT_OVERFLOW;
            else r = a_raw;
         end
         default: begin
            // Negate and absolute value both fail only on MIN.
            if (a == lo) f = cia_pkg::FAULT_OVERFLOW;
            else if (op == cia_pkg::OP_NEG || a < 0) r = -a;
            else r = a;
         end
      endcase
      exp_value_q.push_back(f != cia_pkg::FAULT_NONE ? 64'd0 : r);
      exp_fault_q.push_back(f);
   endfunction

   // Compares one response beat with the oldest expectation.
   function void check_response(logic [63:0] value, logic [2:0] fault);
      logic [63:0] ev;
      logic [2:0]  ef;
      checked++;
      if (exp_value_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: unexpected response value=%h fault=%0d", value, fault);
         return;
      end
      ev = exp_value_q.pop_front();
      ef = exp_fault_q.pop_front();
      if (value !== ev || fault !== ef) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: response %0d: expected value=%h fault=%0d, got value=%h fault=%0d",
                     checked, ev, ef, value, fault);
      end
   endfunction
endclass

module tb;
   import cia_pkg::*;

   localparam int WatchdogLimit = 20000;
   localparam int RandomBeats = 1500;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [2:0]  req_kind = '0;
   logic        req_wide = 0;
   logic [63:0] req_operand_a = '0;
   logic [63:0] req_operand_b = '0;
   logic        rsp_valid;
   logic [63:0] rsp_value;
   logic [2:0]  rsp_fault;

   alu_scoreboard board = new();
   int  idle_pct = 0;
   int  accepted = 0;
   int  quiet_cycles = 0;

   checked_integer_alu uut (
      .clock, .reset, .start, .busy, .req_kind, .req_wide,
      .req_operand_a, .req_operand_b, .rsp_valid, .rsp_value, .rsp_fault
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Check responses and count quiet cycles for the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_response(rsp_value, rsp_fault);
         if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog: too long without any beat moving ends the run.
   always @(posedge clock) begin
      if (quiet_cycles >= WatchdogLimit) begin
         $display("** checked_integer_alu: FAILED **");
         $finish;
      end
   end

   // Presents one beat, holding it until it is accepted.
   task automatic send_beat(op_type op, logic wide, logic [63:0] a, logic [63:0] b);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_kind <= op;
      req_wide <= wide;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (busy);
      board.note_request(op, wide, a, b);
      accepted++;
   endtask

   // Picks an operand that favors edge values of the chosen width.
   function automatic logic [63:0] pick_operand(logic wide);
      logic [63:0] v;
      case ($urandom_range(9))
         0: v = wide ? 64'h8000000000000000 : 64'hffffffff80000000;
         1: v = wide ? 64'h7fffffffffffffff : 64'h000000007fffffff;
         2: v = '1;
         3: v = 64'(int'($urandom_range(6)) - 3);
         4: v = {{48{$urandom_range(1) == 1}}, 16'($urandom)};
         5: v = {{32{$urandom_range(1) == 1}}, 32'($urandom)};
         default: v = {32'($urandom), 32'($urandom)};
      endcase
      return v;
   endfunction

   initial begin
      logic [63:0] mn;
      logic [63:0] mx;
      op_type op;
      logic w;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed beats: edge values and every trap.
      for (int wi = 0; wi < 2; wi++) begin
         w  = 1'(wi);
         mn = w ? 64'h8000000000000000 : 64'hffffffff80000000;
         mx = w ? 64'h7fffffffffffffff : 64'h000000007fffffff;
         send_beat(OP_ADD, w, mx, 64'd1);
         send_beat(OP_ADD, w, mn, '1);
         send_beat(OP_SUB, w, mn, 64'd1);
         send_beat(OP_SUB, w, mx, '1);
         send_beat(OP_MUL, w, mn, '1);
         send_beat(OP_MUL, w, mx, mx);
         send_beat(OP_DIV, w, mn, '1);
         send_beat(OP_MOD, w, mn, '1);
         send_beat(OP_DIV, w, 64'd7, 64'd0);
         send_beat(OP_MOD, w, -64'sd7, 64'd2);
         send_beat(OP_NEG, w, mn, 64'd0);
         send_beat(OP_ABS, w, mn, 64'd0);
      end
      send_beat(OP_NARROW, 1'b0, 64'h0000000080000000, 64'd0);
      send_beat(OP_NARROW, 1'b1, 64'hffffffff7fffffff, 64'd0);
      send_beat(OP_NARROW, 1'b0, 64'hffffffff80000000, 64'd0);

      // Random beats in idling phases, with stretches of none.
      for (int i = 0; i < RandomBeats; i++) begin
         if (i % 300 == 0) begin
            case ((i / 300) % 3)
               0: idle_pct = 0;
               1: idle_pct = 84;
               default: idle_pct = 26;
            endcase
         end
         op = op_type'($urandom_range(7));
         w = 1'($urandom_range(1));
         send_beat(op, w, pick_operand(w), pick_operand(w));
      end
      start <= 0;

      // Drain, then allow for the longest divide.
      while (board.exp_value_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Covered %0d beats over all operations, widths and traps; %0d responses.",
               accepted, board.checked);
      if (board.mismatches == 0 && board.exp_value_q.size() == 0)
         $display("** checked_integer_alu: PASSED **");
      else
         $display("** checked_integer_alu: FAILED **");
      $finish;
   end
endmodule
